[rtl/lpm_pkg.sv]
package lpm_pkg;

	// field widths
	localparam int unsigned MeasW  = 16;
	localparam int unsigned TempW  = 12;
	localparam int unsigned ProdW  = 2 * MeasW;
	localparam int unsigned ThreshW = ProdW + 1;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;

	// counters
	localparam int unsigned PwrCntW = 11;
	localparam int unsigned LimCntW = 3;
	localparam int unsigned PwrCountMax = 2000;
	localparam int unsigned LimCountMax = 5;

	// low gear divide by ten: (x * GearRecip) >> GearShift is exact for 16-bit x
	localparam int unsigned GearRecip = 52429;
	localparam int unsigned GearShift = 19;
	localparam int unsigned PwrDiv    = 100000;

	// register reset values
	localparam int unsigned PowerLimitRst   = 0;
	localparam int unsigned VoltageLimitRst = 65535;
	localparam int unsigned CurrentLimitRst = 65535;
	localparam int unsigned OvertempRst     = 800;
	localparam int unsigned FanOnRst        = 1500;
	localparam int unsigned FanOffRst       = 1700;

	typedef enum logic [CfgIdxW-1:0] {
		REG_POWER_LIMIT   = 3'd0,
		REG_VOLTAGE_LIMIT = 3'd1,
		REG_CURRENT_LIMIT = 3'd2,
		REG_OVERTEMP      = 3'd3,
		REG_FAN_ON        = 3'd4,
		REG_FAN_OFF       = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CAUSE_PWR  = 2'd0,
		CAUSE_OV   = 2'd1,
		CAUSE_OC   = 2'd2,
		CAUSE_TEMP = 2'd3
	} cause_t;

	// power_limit is held as the smallest raw product that counts as over power:
	// floor(p / PwrDiv) > limit  <=>  p >= (limit + 1) * PwrDiv
	typedef struct packed {
		logic [ThreshW-1:0] pwr_thresh;
		logic [MeasW-1:0]   voltage_limit;
		logic [MeasW-1:0]   current_limit;
		logic [TempW-1:0]   overtemp_level;
		logic [TempW-1:0]   fan_on_level;
		logic [TempW-1:0]   fan_off_level;
	} cfg_t;

	typedef struct packed {
		logic [1:0] gear_idx;
		logic       ov_hit;
		logic       oc_hit;
		logic       temp_trip;
		logic       fan_on_req;
		logic       fan_off_req;
	} flags_t;

endpackage

[rtl/lpm_if.sv]
interface lpm_smp_if import lpm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [MeasW-1:0] load_current;
	logic [MeasW-1:0] load_voltage;
	logic [TempW-1:0] thermistor_a;
	logic [TempW-1:0] thermistor_b;
	logic             current_gear_high;
	logic             voltage_gear_high;

	modport source (output valid, load_current, load_voltage, thermistor_a, thermistor_b,
		current_gear_high, voltage_gear_high, input ready);
	modport sink (input valid, load_current, load_voltage, thermistor_a, thermistor_b,
		current_gear_high, voltage_gear_high, output ready);
endinterface

interface lpm_res_if;
	logic       valid;
	logic       ready;
	logic       trip;
	logic [1:0] trip_cause;
	logic       fan_on;

	modport source (output valid, trip, trip_cause, fan_on, input ready);
	modport sink (input valid, trip, trip_cause, fan_on, output ready);
endinterface

interface lpm_cfg_if import lpm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/load_protection_monitor_core.sv]
// A sample's result goes through the input register, gear scaling, product and result
// register, in that order, before it is offered.
// Throughput: one sample per cycle while the receiver takes results; each stage moves whenever its successor has room.
// Reset clears all counters, the fan state and the stage valid bits, and loads the
// limit registers with their reset values; no clearing pass is needed.
module load_protection_monitor_core import lpm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lpm_smp_if.sink   smp,
	lpm_res_if.source res,
	lpm_cfg_if.sink   cfg
);

	cfg_t             regs;
	logic             take;
	logic             valid_s3;
	logic [ProdW-1:0] prod_s3;
	flags_t           flags_s3;

	lpm_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lpm_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.smp      (smp),
		.regs     (regs),
		.take     (take),
		.valid_s3 (valid_s3),
		.prod_s3  (prod_s3),
		.flags_s3 (flags_s3)
	);

	lpm_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.prod_s3  (prod_s3),
		.flags_s3 (flags_s3),
		.regs     (regs),
		.take     (take),
		.res      (res)
	);

endmodule

[rtl/lpm_cfg_regs.sv]
module lpm_cfg_regs import lpm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lpm_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pwr_thresh     <= ThreshW'((PowerLimitRst + 1) * PwrDiv);
			regs_q.voltage_limit  <= MeasW'(VoltageLimitRst);
			regs_q.current_limit  <= MeasW'(CurrentLimitRst);
			regs_q.overtemp_level <= TempW'(OvertempRst);
			regs_q.fan_on_level   <= TempW'(FanOnRst);
			regs_q.fan_off_level  <= TempW'(FanOffRst);
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				REG_POWER_LIMIT: begin
					regs_q.pwr_thresh <= (ThreshW'(cfg.data) + ThreshW'(1))
						* ThreshW'(PwrDiv);
				end
				REG_VOLTAGE_LIMIT: regs_q.voltage_limit  <= cfg.data;
				REG_CURRENT_LIMIT: regs_q.current_limit  <= cfg.data;
				REG_OVERTEMP:      regs_q.overtemp_level <= cfg.data[TempW-1:0];
				REG_FAN_ON:        regs_q.fan_on_level   <= cfg.data[TempW-1:0];
				REG_FAN_OFF:       regs_q.fan_off_level  <= cfg.data[TempW-1:0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/lpm_datapath.sv]
module lpm_datapath import lpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	lpm_smp_if.sink          smp,
	input  cfg_t             regs,
	input  logic             take,
	output logic             valid_s3,
	output logic [ProdW-1:0] prod_s3,
	output flags_t           flags_s3
);

	localparam int unsigned RcpW = MeasW + 16;

	logic             rdy1, rdy2, rdy3;
	logic             valid_s1, valid_s2;
	logic [MeasW-1:0] cur_s1, vol_s1;
	logic [TempW-1:0] ta_s1, tb_s1;
	logic             ig_s1, vg_s1;

	logic [MeasW-1:0] ci_s2, vi_s2;
	flags_t           flags_s2;

	logic [RcpW-1:0]  cur_rcp, vol_rcp;
	logic [MeasW-1:0] ci, vi;
	flags_t           flags;
	logic [ProdW-1:0] prod;

	// each stage moves when empty or when its successor moves
	assign rdy3      = !valid_s3 || take;
	assign rdy2      = !valid_s2 || rdy3;
	assign rdy1      = !valid_s1 || rdy2;
	assign smp.ready = rdy1;

	// low gear: divide by ten through a reciprocal
	assign cur_rcp = RcpW'(cur_s1) * RcpW'(GearRecip);
	assign vol_rcp = RcpW'(vol_s1) * RcpW'(GearRecip);
	assign ci = ig_s1 ? cur_s1 : MeasW'(cur_rcp[RcpW-1:GearShift]);
	assign vi = vg_s1 ? vol_s1 : MeasW'(vol_rcp[RcpW-1:GearShift]);

	always_comb begin
		flags.gear_idx    = {ig_s1, vg_s1};
		flags.ov_hit      = vg_s1 && (vol_s1 > regs.voltage_limit);
		flags.oc_hit      = ig_s1 && (cur_s1 > regs.current_limit);
		flags.temp_trip   = (ta_s1 < regs.overtemp_level) || (tb_s1 < regs.overtemp_level);
		flags.fan_on_req  = (ta_s1 <= regs.fan_on_level) || (tb_s1 <= regs.fan_on_level);
		flags.fan_off_req = (ta_s1 >= regs.fan_off_level) && (tb_s1 >= regs.fan_off_level);
	end

	assign prod = ProdW'(ci_s2) * ProdW'(vi_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= smp.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && smp.valid) begin
			cur_s1 <= smp.load_current;
			vol_s1 <= smp.load_voltage;
			ta_s1  <= smp.thermistor_a;
			tb_s1  <= smp.thermistor_b;
			ig_s1  <= smp.current_gear_high;
			vg_s1  <= smp.voltage_gear_high;
		end
		if (rdy2 && valid_s1) begin
			ci_s2    <= ci;
			vi_s2    <= vi;
			flags_s2 <= flags;
		end
		if (rdy3 && valid_s2) begin
			prod_s3  <= prod;
			flags_s3 <= flags_s2;
		end
	end

endmodule

[rtl/lpm_state.sv]
module lpm_state import lpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s3,
	input  logic [ProdW-1:0] prod_s3,
	input  flags_t           flags_s3,
	input  cfg_t             regs,
	output logic             take,
	lpm_res_if.source        res
);

	logic [PwrCntW-1:0] pwr_cnt_q [4];
	logic [LimCntW-1:0] ov_cnt_q, oc_cnt_q;
	logic               fan_q;

	logic               out_valid_q;
	logic               trip_q;
	cause_t             cause_q;
	logic               fan_out_q;

	logic               fire;
	logic               pwr_hit;
	logic [PwrCntW-1:0] pwr_cnt;
	logic               pwr_wrap, ov_wrap, oc_wrap;
	logic               trip;
	cause_t             cause;
	logic               fan_nxt;

	assign take = !out_valid_q || res.ready;
	assign fire = valid_s3 && take;

	assign pwr_hit  = {1'b0, prod_s3} >= regs.pwr_thresh;
	assign pwr_cnt  = pwr_cnt_q[flags_s3.gear_idx];
	assign pwr_wrap = pwr_hit && (pwr_cnt == PwrCntW'(PwrCountMax));
	assign ov_wrap  = flags_s3.ov_hit && (ov_cnt_q == LimCntW'(LimCountMax));
	assign oc_wrap  = flags_s3.oc_hit && (oc_cnt_q == LimCntW'(LimCountMax));

	assign trip = flags_s3.temp_trip || pwr_wrap || ov_wrap || oc_wrap;

	always_comb begin
		if (oc_wrap)                 cause = CAUSE_OC;
		else if (ov_wrap)            cause = CAUSE_OV;
		else if (pwr_wrap)           cause = CAUSE_PWR;
		else if (flags_s3.temp_trip) cause = CAUSE_TEMP;
		else                         cause = CAUSE_PWR;
	end

	// on request wins; between levels hold the fan as it is
	always_comb begin
		if (flags_s3.fan_on_req)       fan_nxt = 1'b1;
		else if (flags_s3.fan_off_req) fan_nxt = 1'b0;
		else                           fan_nxt = fan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) pwr_cnt_q[i] <= '0;
			ov_cnt_q    <= '0;
			oc_cnt_q    <= '0;
			fan_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) out_valid_q <= valid_s3;
			if (fire) begin
				fan_q <= fan_nxt;
				if (pwr_hit) begin
					pwr_cnt_q[flags_s3.gear_idx] <= pwr_wrap ? '0 : pwr_cnt + 1'b1;
				end
				if (flags_s3.ov_hit) ov_cnt_q <= ov_wrap ? '0 : ov_cnt_q + 1'b1;
				if (flags_s3.oc_hit) oc_cnt_q <= oc_wrap ? '0 : oc_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			trip_q    <= trip;
			cause_q   <= cause;
			fan_out_q <= fan_nxt;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.trip       = trip_q;
	assign res.trip_cause = cause_q;
	assign res.fan_on     = fan_out_q;

	a_pwr_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pwr_cnt_q[0] <= PwrCntW'(PwrCountMax)) && (pwr_cnt_q[1] <= PwrCntW'(PwrCountMax)) &&
		(pwr_cnt_q[2] <= PwrCntW'(PwrCountMax)) && (pwr_cnt_q[3] <= PwrCntW'(PwrCountMax)))
		else $error("power counter beyond its limit");

	a_lim_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_cnt_q <= LimCntW'(LimCountMax)) && (oc_cnt_q <= LimCntW'(LimCountMax)))
		else $error("limit counter beyond its limit");

	a_pwr_wrap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pwr_wrap |=> pwr_cnt_q[$past(flags_s3.gear_idx)] == '0)
		else $error("power counter not cleared on trip");

	a_quiet_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.trip |-> res.trip_cause == CAUSE_PWR)
		else $error("cause set without trip");

endmodule

[dv/tb_load_protection_monitor_core.sv]
module tb_load_protection_monitor_core;
	timeunit 1ns;
	timeprecision 1ps;
	import lpm_pkg::*;

	localparam int IdlePct    = 35;
	localparam int HoldCycles = 400;
	localparam int StallLimit = 3000;
	localparam int DrainWait  = 8;
	localparam int ReportMax  = 10;
	localparam int PhaseItems = 150;
	localparam int SoakMax    = 1070;
	localparam int SoakTail   = 100;

	// indexes past the last register; writes there must change nothing
	localparam logic [CfgIdxW-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_SPARE_7 = 3'd7;

	typedef struct {
		logic [MeasW-1:0] current;
		logic [MeasW-1:0] voltage;
		logic [TempW-1:0] therm_a;
		logic [TempW-1:0] therm_b;
		logic             cur_high;
		logic             volt_high;
	} sample_t;

	typedef struct {
		logic   trip;
		cause_t cause;
		logic   fan;
	} verdict_t;

	typedef struct {
		bit                  is_reg;
		logic [CfgIdxW-1:0]  reg_idx;
		logic [CfgDataW-1:0] reg_data;
		sample_t             smp;
		bit                  known;
		verdict_t            verdict;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;

	lpm_smp_if smp_bus ();
	lpm_res_if res_bus ();
	lpm_cfg_if cfg_bus ();

	load_protection_monitor_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// limits and protection state as the block should hold them
	logic [MeasW-1:0]   lim_power    = MeasW'(PowerLimitRst);
	logic [MeasW-1:0]   lim_volt     = MeasW'(VoltageLimitRst);
	logic [MeasW-1:0]   lim_cur      = MeasW'(CurrentLimitRst);
	logic [TempW-1:0]   lim_overtemp = TempW'(OvertempRst);
	logic [TempW-1:0]   lim_fan_on   = TempW'(FanOnRst);
	logic [TempW-1:0]   lim_fan_off  = TempW'(FanOffRst);
	logic [PwrCntW-1:0] gear_power_count [4] = '{default: '0};
	logic [LimCntW-1:0] ov_streak = '0;
	logic [LimCntW-1:0] oc_streak = '0;
	logic               fan_level = 1'b0;
	int                 power_trip_tally = 0;

	verdict_t verdict_queue [$];
	int       samples_sent = 0;
	int       results_seen = 0;
	int       fault_count = 0;
	int       stall_cycles = 0;

	// sideband travelling with the payload: a typed-in expectation overrides the prediction
	bit       typed_known;
	verdict_t typed_verdict;

	bit idle_en;
	bit hold_req;
	bit hold_ack = 1'b0;
	int hold_left = 0;

	function automatic verdict_t protect_tick(sample_t s);
		verdict_t            v;
		logic [MeasW-1:0]    cur_scaled;
		logic [MeasW-1:0]    volt_scaled;
		logic [ProdW-1:0]    product;
		logic [ProdW-1:0]    power;
		logic [1:0]          gear;
		bit                  temp_hit;
		bit                  pwr_trip;
		bit                  ov_trip;
		bit                  oc_trip;

		temp_hit = s.therm_a < lim_overtemp || s.therm_b < lim_overtemp;
		// on wins over off; between the levels the fan holds
		if (s.therm_a <= lim_fan_on || s.therm_b <= lim_fan_on) begin
			fan_level = 1'b1;
		end else if (s.therm_a >= lim_fan_off && s.therm_b >= lim_fan_off) begin
			fan_level = 1'b0;
		end

		cur_scaled = s.cur_high ? s.current : s.current / MeasW'(10);
		volt_scaled = s.volt_high ? s.voltage : s.voltage / MeasW'(10);
		product = ProdW'(cur_scaled) * ProdW'(volt_scaled);
		power = product / ProdW'(PwrDiv);
		gear = {s.cur_high, s.volt_high};

		pwr_trip = 1'b0;
		ov_trip = 1'b0;
		oc_trip = 1'b0;
		if (power > ProdW'(lim_power)) begin
			if (gear_power_count[gear] == PwrCntW'(PwrCountMax)) begin
				gear_power_count[gear] = '0;
				pwr_trip = 1'b1;
				power_trip_tally++;
			end else begin
				gear_power_count[gear]++;
			end
		end
		if (s.volt_high && s.voltage > lim_volt) begin
			if (ov_streak == LimCntW'(LimCountMax)) begin
				ov_streak = '0;
				ov_trip = 1'b1;
			end else begin
				ov_streak++;
			end
		end
		if (s.cur_high && s.current > lim_cur) begin
			if (oc_streak == LimCntW'(LimCountMax)) begin
				oc_streak = '0;
				oc_trip = 1'b1;
			end else begin
				oc_streak++;
			end
		end

		v.trip = temp_hit || pwr_trip || ov_trip || oc_trip;
		if (oc_trip) begin
			v.cause = CAUSE_OC;
		end else if (ov_trip) begin
			v.cause = CAUSE_OV;
		end else if (pwr_trip) begin
			v.cause = CAUSE_PWR;
		end else if (temp_hit) begin
			v.cause = CAUSE_TEMP;
		end else begin
			v.cause = CAUSE_PWR;
		end
		v.fan = fan_level;
		return v;
	endfunction

	function automatic logic [TempW-1:0] draw_therm();
		logic [TempW-1:0] lvl;

		case ($urandom_range(3))
			0: lvl = lim_overtemp;
			1: lvl = lim_fan_on;
			2: lvl = lim_fan_off;
			default: return TempW'($urandom);
		endcase
		return lvl + TempW'($urandom_range(4)) - TempW'(2);
	endfunction

	function automatic sample_t draw_sample(bit soak);
		sample_t s;

		s.current = MeasW'($urandom);
		s.voltage = MeasW'($urandom);
		s.cur_high = 1'($urandom);
		s.volt_high = 1'($urandom);
		case ($urandom_range(3))
			0: begin
				// straddle the over-current and over-voltage thresholds
				s.current = lim_cur + MeasW'($urandom_range(2)) - MeasW'(1);
				s.voltage = lim_volt + MeasW'($urandom_range(2)) - MeasW'(1);
			end
			1: begin
				s.current = MeasW'($urandom_range(3000));
				s.voltage = MeasW'($urandom_range(3000));
			end
			default: ;
		endcase
		s.therm_a = draw_therm();
		s.therm_b = draw_therm();
		// keep one gear well over the power limit so its counter climbs
		if (soak && $urandom_range(99) < 95) begin
			s.cur_high = 1'b1;
			s.volt_high = 1'b1;
			s.current = MeasW'($urandom_range(65535, 1000));
			s.voltage = MeasW'($urandom_range(65535, 1000));
		end
		return s;
	endfunction

	function automatic step_t sample_step(int cur, int volt, int ta, int tb, bit ch, bit vh,
			bit known, bit trip, cause_t cause, bit fan);
		step_t st;

		st.is_reg = 1'b0;
		st.reg_idx = '0;
		st.reg_data = '0;
		st.smp.current = MeasW'(cur);
		st.smp.voltage = MeasW'(volt);
		st.smp.therm_a = TempW'(ta);
		st.smp.therm_b = TempW'(tb);
		st.smp.cur_high = ch;
		st.smp.volt_high = vh;
		st.known = known;
		st.verdict.trip = trip;
		st.verdict.cause = cause;
		st.verdict.fan = fan;
		return st;
	endfunction

	function automatic step_t reg_step(logic [CfgIdxW-1:0] idx, int data);
		step_t st;

		st = sample_step(0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0, CAUSE_PWR, 1'b0);
		st.is_reg = 1'b1;
		st.reg_idx = idx;
		st.reg_data = CfgDataW'(data);
		return st;
	endfunction

	task automatic offer_sample(sample_t s, bit known, verdict_t v);
		while (idle_en && $urandom_range(99) < IdlePct) begin
			smp_bus.valid <= 1'b0;
			@(posedge clk);
		end
		smp_bus.valid <= 1'b1;
		smp_bus.load_current <= s.current;
		smp_bus.load_voltage <= s.voltage;
		smp_bus.thermistor_a <= s.therm_a;
		smp_bus.thermistor_b <= s.therm_b;
		smp_bus.current_gear_high <= s.cur_high;
		smp_bus.voltage_gear_high <= s.volt_high;
		typed_known <= known;
		typed_verdict <= v;
		do @(posedge clk); while (!smp_bus.ready);
		samples_sent++;
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// drop the sample valid, wait for every outstanding result, then let the pipe empty
	task automatic settle();
		smp_bus.valid <= 1'b0;
		while (results_seen < samples_sent) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				res_bus.ready <= 1'b0;
				hold_left--;
			end else if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = HoldCycles - 1;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= !(idle_en && $urandom_range(99) < IdlePct);
			end
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		sample_t  seen;
		bit       moved;

		if (arst_n) begin
			moved = 1'b0;
			if (res_bus.valid && res_bus.ready) begin
				moved = 1'b1;
				results_seen++;
				if (verdict_queue.size() == 0) begin
					fault_count++;
					if (fault_count <= ReportMax) begin
						$display("%0t: result with none expected: trip %0b cause %0d fan %0b",
							$time, res_bus.trip, res_bus.trip_cause, res_bus.fan_on);
					end
				end else begin
					want = verdict_queue.pop_front();
					if (res_bus.trip !== want.trip || res_bus.trip_cause !== want.cause ||
							res_bus.fan_on !== want.fan) begin
						fault_count++;
						if (fault_count <= ReportMax) begin
							$display("%0t: expected trip %0b cause %0d fan %0b, got trip %0b cause %0d fan %0b",
								$time, want.trip, want.cause, want.fan,
								res_bus.trip, res_bus.trip_cause, res_bus.fan_on);
						end
					end
				end
			end
			if (cfg_bus.valid && cfg_bus.ready) begin
				moved = 1'b1;
				case (cfg_bus.index)
					REG_POWER_LIMIT:   lim_power = cfg_bus.data;
					REG_VOLTAGE_LIMIT: lim_volt = cfg_bus.data;
					REG_CURRENT_LIMIT: lim_cur = cfg_bus.data;
					REG_OVERTEMP:      lim_overtemp = cfg_bus.data[TempW-1:0];
					REG_FAN_ON:        lim_fan_on = cfg_bus.data[TempW-1:0];
					REG_FAN_OFF:       lim_fan_off = cfg_bus.data[TempW-1:0];
					default: ;
				endcase
			end
			if (smp_bus.valid && smp_bus.ready) begin
				moved = 1'b1;
				seen.current = smp_bus.load_current;
				seen.voltage = smp_bus.load_voltage;
				seen.therm_a = smp_bus.thermistor_a;
				seen.therm_b = smp_bus.thermistor_b;
				seen.cur_high = smp_bus.current_gear_high;
				seen.volt_high = smp_bus.voltage_gear_high;
				want = protect_tick(seen);
				if (typed_known) begin
					want = typed_verdict;
				end
				verdict_queue.push_back(want);
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles == StallLimit) begin
				$display("tb_load_protection_monitor_core: FAIL");
				$finish;
			end
		end
	end

	initial begin
		step_t      directed [$];
		verdict_t   unknown_verdict;
		cfg_idx_t   reg_order [6];
		int         limits [6];
		int         n;
		int         tail;

		arst_n <= 1'b0;
		smp_bus.valid <= 1'b0;
		smp_bus.load_current <= '0;
		smp_bus.load_voltage <= '0;
		smp_bus.thermistor_a <= '0;
		smp_bus.thermistor_b <= '0;
		smp_bus.current_gear_high <= 1'b0;
		smp_bus.voltage_gear_high <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_POWER_LIMIT;
		cfg_bus.data <= '0;
		typed_known <= 1'b0;
		idle_en <= 1'b1;
		hold_req <= 1'b0;
		unknown_verdict.trip = 1'b0;
		unknown_verdict.cause = CAUSE_PWR;
		unknown_verdict.fan = 1'b0;
		reg_order = '{REG_POWER_LIMIT, REG_VOLTAGE_LIMIT, REG_CURRENT_LIMIT,
			REG_OVERTEMP, REG_FAN_ON, REG_FAN_OFF};

		directed = '{
			// reset limits: fan hysteresis and over-temperature edges
			sample_step(0, 0, 4095, 4095, 0, 0, 1, 0, CAUSE_PWR, 0),
			sample_step(65535, 65535, 4095, 4095, 1, 1, 1, 0, CAUSE_PWR, 0),
			sample_step(0, 0, 0, 4095, 0, 0, 1, 1, CAUSE_TEMP, 1),
			sample_step(0, 0, 1600, 1600, 0, 0, 1, 0, CAUSE_PWR, 1),
			sample_step(0, 0, 1700, 4095, 0, 0, 1, 0, CAUSE_PWR, 0),
			sample_step(0, 0, 1600, 1699, 0, 0, 1, 0, CAUSE_PWR, 0),
			sample_step(0, 0, 4095, 1500, 0, 0, 1, 0, CAUSE_PWR, 1),
			sample_step(0, 0, 800, 800, 0, 0, 1, 0, CAUSE_PWR, 1),
			sample_step(0, 0, 4095, 799, 0, 0, 1, 1, CAUSE_TEMP, 1),
			sample_step(65535, 65535, 4095, 4095, 0, 1, 1, 0, CAUSE_PWR, 0),
			// both debounce counters run out together: over-current wins
			reg_step(REG_VOLTAGE_LIMIT, 0),
			reg_step(REG_CURRENT_LIMIT, 0),
			sample_step(1, 1, 4095, 4095, 1, 1, 0, 0, CAUSE_PWR, 0),
			sample_step(1, 1, 4095, 4095, 1, 1, 0, 0, CAUSE_PWR, 0),
			sample_step(1, 1, 4095, 4095, 1, 1, 0, 0, CAUSE_PWR, 0),
			sample_step(1, 1, 4095, 4095, 1, 1, 0, 0, CAUSE_PWR, 0),
			sample_step(1, 1, 4095, 4095, 1, 1, 0, 0, CAUSE_PWR, 0),
			sample_step(1, 1, 4095, 4095, 1, 1, 1, 1, CAUSE_OC, 0),
			// low current gear: over-voltage alone
			sample_step(1, 1, 4095, 4095, 0, 1, 0, 0, CAUSE_PWR, 0),
			sample_step(1, 1, 4095, 4095, 0, 1, 0, 0, CAUSE_PWR, 0),
			sample_step(1, 1, 4095, 4095, 0, 1, 0, 0, CAUSE_PWR, 0),
			sample_step(1, 1, 4095, 4095, 0, 1, 0, 0, CAUSE_PWR, 0),
			sample_step(1, 1, 4095, 4095, 0, 1, 0, 0, CAUSE_PWR, 0),
			sample_step(1, 1, 4095, 4095, 0, 1, 1, 1, CAUSE_OV, 0),
			// extreme limits, masking of the narrow registers, spare indexes
			reg_step(REG_POWER_LIMIT, 65535),
			reg_step(REG_OVERTEMP, 65535),
			reg_step(REG_FAN_ON, 0),
			reg_step(REG_FAN_OFF, 4095),
			reg_step(REG_SPARE_6, 255),
			reg_step(REG_SPARE_7, 255),
			sample_step(65535, 65535, 4094, 4095, 1, 1, 0, 0, CAUSE_PWR, 0),
			sample_step(0, 0, 0, 0, 0, 0, 0, 0, CAUSE_PWR, 0),
			sample_step(65535, 65535, 4095, 4095, 1, 0, 0, 0, CAUSE_PWR, 0)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_reg) begin
				settle();
				write_reg(directed[i].reg_idx, directed[i].reg_data);
			end else begin
				offer_sample(directed[i].smp, directed[i].known, directed[i].verdict);
			end
		end

		for (int ph = 0; ph < 5; ph++) begin
			settle();
			case (ph)
				0: limits = '{0, 0, 0, 0, 0, 0};
				1: limits = '{65535, 65535, 65535, 4095, 4095, 4095};
				4: limits = '{0, $urandom_range(65535, 20000), $urandom_range(65535, 20000),
					$urandom_range(1200, 300), $urandom_range(4095), $urandom_range(4095)};
				default: limits = '{$urandom_range(20000), $urandom_range(65535),
					$urandom_range(65535), $urandom_range(4095), $urandom_range(4095),
					$urandom_range(4095)};
			endcase
			for (int r = 0; r < 6; r++) begin
				write_reg(reg_order[r], CfgDataW'(limits[r]));
			end
			if (ph < 4) begin
				idle_en <= 1'b1;
				repeat (PhaseItems) offer_sample(draw_sample(1'b0), 1'b0, unknown_verdict);
			end else begin
				// soak one gear to drive its power counter up; start without gaps and
				// hold the receiver off so the pipe backs up
				idle_en <= 1'b0;
				n = 0;
				tail = 0;
				while (tail < SoakTail && n < SoakMax) begin
					if (n == 40) begin
						hold_req <= ~hold_req;
					end
					if (n == 300) begin
						idle_en <= 1'b1;
					end
					offer_sample(draw_sample(1'b1), 1'b0, unknown_verdict);
					n++;
					if (power_trip_tally != 0) begin
						tail++;
					end
				end
			end
		end

		settle();
		if (fault_count == 0 && verdict_queue.size() == 0) begin
			$display("tb_load_protection_monitor_core: PASS");
		end else begin
			$display("tb_load_protection_monitor_core: FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/lpm_pkg.sv
rtl/lpm_if.sv
rtl/lpm_cfg_regs.sv
rtl/lpm_datapath.sv
rtl/lpm_state.sv
rtl/load_protection_monitor_core.sv
dv/tb_load_protection_monitor_core.sv
